>>> rtl/sbi_pkg.sv
// Shared constants, types and helper functions of the segment/box intersection pipeline.
`default_nettype none

package sbi_pkg;

  localparam int NAX       = 3;           // axes x, y, z
  localparam int CW        = 32;          // coordinate width, Q16.16
  localparam int DW        = CW + 1;      // exact difference of two coordinates
  localparam int FRAC_BITS = 16;
  localparam int QW        = 18;          // quotient magnitude bits kept
  localparam int TW        = QW + 1;      // signed t
  localparam int RW        = DW + QW;     // divider remainder
  localparam int PW        = TW + DW;     // t times difference
  localparam int KW        = 37;          // coordinate at t
  localparam int VW        = 40;          // range-test operand width
  localparam int TOLW      = 16;
  localparam int DIV_LAT   = QW + 2;      // prep, one stage per quotient bit, sign
  localparam int CRD_LAT   = 3;           // multiply, rescale and add, range test
  localparam int LAT       = DIV_LAT + CRD_LAT + 3;  // input, differences, hit

  localparam logic [TOLW-1:0] TOL_RST = 16'd1;
  localparam logic signed [VW-1:0] T_ONE = 40'sd65536;

  typedef struct packed {
    logic [NAX-1:0][CW-1:0] s0;       // segment start
    logic [NAX-1:0][CW-1:0] lo;       // box lower corner
    logic [NAX-1:0][CW-1:0] hi;       // box upper corner
    logic [NAX-1:0][DW-1:0] den;      // end minus start
    logic [NAX-1:0]         dok;      // difference outside tolerance
    logic [NAX-1:0][1:0]    inpl;     // segment lies in face plane
  } side_t;

  typedef struct packed {
    logic [NAX-1:0]      dok;
    logic [NAX-1:0][1:0] inpl;
    logic [NAX-1:0][1:0] tp;          // t passed its [0,1] test
  } flag_t;

  // Index of the j-th remaining axis once axis q is taken out.
  function automatic int oth(input int q, input int j);
    if (j == 0) begin
      return (q == 0) ? 1 : 0;
    end
    return (q == 2) ? 1 : 2;
  endfunction

  function automatic logic wtol(input logic signed [DW:0] d, input logic [TOLW-1:0] tol);
    logic signed [DW:0] tw;
    tw = signed'((DW+1)'(tol));
    return (d >= -tw) && (d <= tw);
  endfunction

  function automatic logic in_rng(input logic signed [VW-1:0] lo,
                                  input logic signed [VW-1:0] hi,
                                  input logic signed [VW-1:0] v,
                                  input logic [TOLW-1:0] tol);
    logic signed [VW:0] dl;
    logic signed [VW:0] dh;
    logic signed [VW:0] tw;
    dl = (VW+1)'(v) - (VW+1)'(lo);
    dh = (VW+1)'(v) - (VW+1)'(hi);
    tw = signed'((VW+1)'(tol));
    return ((lo <= v) && (v <= hi)) || ((dl >= -tw) && (dl <= tw)) ||
           ((dh >= -tw) && (dh <= tw));
  endfunction

endpackage

`default_nettype wire

>>> rtl/sbi_div.sv
// Pipelined restoring divider giving t at a face plane and its range verdict.
`default_nettype none

module sbi_div (
  input  logic                                clk,
  input  logic                                adv,
  input  logic [sbi_pkg::TOLW-1:0]            tol,
  input  logic signed [sbi_pkg::DW-1:0]       num_i,
  input  logic signed [sbi_pkg::DW-1:0]       den_i,
  output logic signed [sbi_pkg::TW-1:0]       t_o,
  output logic                                tpass_o
);

  localparam int QW = sbi_pkg::QW;
  localparam int DW = sbi_pkg::DW;
  localparam int RW = sbi_pkg::RW;
  localparam int TW = sbi_pkg::TW;

  logic [DW-1:0] na_c;
  logic [DW-1:0] da_c;
  logic          ovf_c;

  logic [RW-1:0] rem_r [0:QW-1];
  logic [DW-1:0] d_r   [0:QW-1];
  logic [QW-1:0] q_r   [0:QW];
  logic          sg_r  [0:QW];
  logic          ov_r  [0:QW];

  logic signed [TW-1:0] tq_c;
  logic signed [TW-1:0] t_nxt;
  logic signed [TW-1:0] t_r;
  logic                 tpass_r;

  always_comb begin
    na_c  = num_i[DW-1] ? DW'(-num_i) : DW'(num_i);
    da_c  = den_i[DW-1] ? DW'(-den_i) : DW'(den_i);
    // quotient would need more than QW bits: t is far outside [0,1]
    ovf_c = {2'b00, na_c} >= {da_c, 2'b00};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= RW'({na_c, {sbi_pkg::FRAC_BITS{1'b0}}});
      d_r[0]   <= da_c;
      q_r[0]   <= '0;
      sg_r[0]  <= num_i[DW-1] ^ den_i[DW-1];
      ov_r[0]  <= ovf_c;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int SH = QW - 1 - k;
    logic [RW-1:0] sub_w;
    logic          ge_w;
    assign sub_w = RW'(d_r[k]) << SH;
    assign ge_w  = rem_r[k] >= sub_w;

    always_ff @(posedge clk) begin
      if (adv) begin
        q_r[k+1]  <= q_r[k] | (QW'(ge_w) << SH);
        sg_r[k+1] <= sg_r[k];
        ov_r[k+1] <= ov_r[k];
      end
    end

    if (k < QW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[k+1] <= ge_w ? (rem_r[k] - sub_w) : rem_r[k];
          d_r[k+1]   <= d_r[k];
        end
      end
    end
  end

  always_comb begin
    tq_c  = $signed({1'b0, q_r[QW]});
    t_nxt = sg_r[QW] ? -tq_c : tq_c;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t_r     <= t_nxt;
      tpass_r <= !ov_r[QW] &&
                 sbi_pkg::in_rng('0, sbi_pkg::T_ONE, sbi_pkg::VW'(t_nxt), tol);
    end
  end

  assign t_o     = t_r;
  assign tpass_o = tpass_r;

endmodule

`default_nettype wire

>>> rtl/sbi_side_dly.sv
// Delay line that keeps per-item side data aligned with the divider output.
`default_nettype none

module sbi_side_dly (
  input  logic           clk,
  input  logic           adv,
  input  sbi_pkg::side_t side_i,
  output sbi_pkg::side_t side_o
);

  sbi_pkg::side_t sr_r [0:sbi_pkg::DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      sr_r[0] <= side_i;
      for (int k = 1; k < sbi_pkg::DIV_LAT; k++) begin
        sr_r[k] <= sr_r[k-1];
      end
    end
  end

  assign side_o = sr_r[sbi_pkg::DIV_LAT-1];

endmodule

`default_nettype wire

>>> rtl/sbi_coord.sv
// Coordinate at parameter t and its tolerant range test against a box slab.
`default_nettype none

module sbi_coord (
  input  logic                              clk,
  input  logic                              adv,
  input  logic [sbi_pkg::TOLW-1:0]          tol,
  input  logic signed [sbi_pkg::TW-1:0]     t_i,
  input  logic signed [sbi_pkg::CW-1:0]     c0_i,
  input  logic signed [sbi_pkg::DW-1:0]     dc_i,
  input  logic signed [sbi_pkg::CW-1:0]     lo_i,
  input  logic signed [sbi_pkg::CW-1:0]     hi_i,
  output logic                              inr_o
);

  localparam int PW = sbi_pkg::PW;
  localparam int KW = sbi_pkg::KW;
  localparam int CW = sbi_pkg::CW;
  localparam logic signed [PW-1:0] RND = (1 <<< sbi_pkg::FRAC_BITS) - 1;

  logic signed [PW-1:0] prod_r;
  logic signed [CW-1:0] c0_r;
  logic signed [CW-1:0] lo1_r;
  logic signed [CW-1:0] hi1_r;
  logic signed [PW-1:0] adj_c;
  logic signed [KW-1:0] crd_nxt;
  logic signed [KW-1:0] crd_r;
  logic signed [CW-1:0] lo2_r;
  logic signed [CW-1:0] hi2_r;
  logic                 inr_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= PW'(t_i) * PW'(dc_i);
      c0_r   <= c0_i;
      lo1_r  <= lo_i;
      hi1_r  <= hi_i;
    end
  end

  // rescale by 2^-16 truncating toward zero
  always_comb begin
    adj_c   = prod_r[PW-1] ? (prod_r + RND) : prod_r;
    crd_nxt = KW'(c0_r) + KW'(adj_c >>> sbi_pkg::FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      crd_r <= crd_nxt;
      lo2_r <= lo1_r;
      hi2_r <= hi1_r;
      inr_r <= sbi_pkg::in_rng(sbi_pkg::VW'(lo2_r), sbi_pkg::VW'(hi2_r),
                               sbi_pkg::VW'(crd_r), tol);
    end
  end

  assign inr_o = inr_r;

endmodule

`default_nettype wire

>>> rtl/segment_box_intersect.sv
// Top level: streaming segment against axis-aligned box face intersection test.
//
// Input channel in_*: one transfer carries a segment (start, end) and a box
// (lower, upper corner), twelve signed Q16.16 coordinates in in_tdata.
// Output channel out_*: one transfer per input transfer, out_tdata[0] = hit.
// Configuration: cfg_wr_en writes cfg_wr_data into the tolerance register;
// write it only while no item is in flight.
//
// Throughput: one item per cycle while the skid slot is free, set by the
// pipelined dividers (one quotient bit per stage) that run the six face
// planes side by side.
//
// Reset (rst_n low, synchronous): valid bits, output register and skid slot
// clear, tolerance returns to 1. When the receiver stalls, a full output
// register takes one further result in a skid slot; in_tready then drops and
// the whole pipeline holds until the slot drains. Nothing is lost or repeated.
`default_nettype none

module segment_box_intersect (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z, box_min_x, box_min_y,
  // box_min_z, box_max_x, box_max_y, box_max_z (32 bits each, lowest first)
  input  logic [383:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // hit in bit 0, bits 7:1 zero
  output logic [7:0]   out_tdata,
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data
);

  localparam int NAX = sbi_pkg::NAX;
  localparam int CW  = sbi_pkg::CW;
  localparam int DW  = sbi_pkg::DW;
  localparam int TW  = sbi_pkg::TW;
  localparam int LAT = sbi_pkg::LAT;
  localparam int CRD_LAT = sbi_pkg::CRD_LAT;

  logic [sbi_pkg::TOLW-1:0] tol_r;
  logic                     adv;
  logic [LAT-1:0]           v_r;

  logic [4*NAX-1:0][CW-1:0]     in_r;
  sbi_pkg::side_t               side_nxt;
  sbi_pkg::side_t               side2_r;
  logic [NAX-1:0][1:0][DW-1:0]  dpl_nxt;
  logic [NAX-1:0][1:0][DW-1:0]  dpl2_r;
  sbi_pkg::side_t               side_d;

  logic [NAX-1:0][1:0][TW-1:0]  t_w;
  logic [NAX-1:0][1:0]          tp_w;
  logic [NAX-1:0][1:0][1:0]     inr_w;
  sbi_pkg::flag_t               fl_r [0:CRD_LAT-1];

  logic [NAX-1:0] rect_c;
  logic           hit_nxt;
  logic           hit_r;

  logic out_v_r;
  logic out_hit_r;
  logic skid_v_r;
  logic skid_hit_r;
  logic deliver;

  // tolerance register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= sbi_pkg::TOL_RST;
    end else if (cfg_wr_en) begin
      tol_r <= cfg_wr_data;
    end
  end

  // the pipeline advances as one while the skid slot is free
  assign adv       = !skid_v_r;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[LAT-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_r <= in_tdata;
    end
  end

  // differences along each axis, plane-in and parallel flags
  always_comb begin
    logic signed [CW-1:0] s0;
    logic signed [CW-1:0] e;
    logic signed [CW-1:0] lo;
    logic signed [CW-1:0] hi;
    logic signed [DW-1:0] den;
    logic signed [DW-1:0] dlo;
    logic signed [DW-1:0] dhi;
    logic signed [DW-1:0] elo;
    logic signed [DW-1:0] ehi;
    for (int a = 0; a < NAX; a++) begin
      s0  = $signed(in_r[a]);
      e   = $signed(in_r[NAX + a]);
      lo  = $signed(in_r[2*NAX + a]);
      hi  = $signed(in_r[3*NAX + a]);
      den = DW'(e) - DW'(s0);
      dlo = DW'(lo) - DW'(s0);
      dhi = DW'(hi) - DW'(s0);
      elo = DW'(e) - DW'(lo);
      ehi = DW'(e) - DW'(hi);
      side_nxt.s0[a]  = s0;
      side_nxt.lo[a]  = lo;
      side_nxt.hi[a]  = hi;
      side_nxt.den[a] = den;
      side_nxt.dok[a] = !sbi_pkg::wtol((DW+1)'(den), tol_r);
      side_nxt.inpl[a][0] = sbi_pkg::wtol((DW+1)'(dlo), tol_r) &&
                            sbi_pkg::wtol((DW+1)'(elo), tol_r);
      side_nxt.inpl[a][1] = sbi_pkg::wtol((DW+1)'(dhi), tol_r) &&
                            sbi_pkg::wtol((DW+1)'(ehi), tol_r);
      dpl_nxt[a][0] = dlo;
      dpl_nxt[a][1] = dhi;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side2_r <= side_nxt;
      dpl2_r  <= dpl_nxt;
    end
  end

  // one t per axis and plane: the face test and the rectangle crossing
  // tests of the neighbouring faces share it
  for (genvar q = 0; q < NAX; q++) begin : g_ax
    for (genvar p = 0; p < 2; p++) begin : g_pl
      sbi_div u_div (
        .clk     (clk),
        .adv     (adv),
        .tol     (tol_r),
        .num_i   ($signed(dpl2_r[q][p])),
        .den_i   ($signed(side2_r.den[q])),
        .t_o     (t_w[q][p]),
        .tpass_o (tp_w[q][p])
      );
      for (genvar j = 0; j < 2; j++) begin : g_oth
        localparam int O = sbi_pkg::oth(q, j);
        sbi_coord u_crd (
          .clk   (clk),
          .adv   (adv),
          .tol   (tol_r),
          .t_i   ($signed(t_w[q][p])),
          .c0_i  ($signed(side_d.s0[O])),
          .dc_i  ($signed(side_d.den[O])),
          .lo_i  ($signed(side_d.lo[O])),
          .hi_i  ($signed(side_d.hi[O])),
          .inr_o (inr_w[q][p][j])
        );
      end
    end
  end

  sbi_side_dly u_side (
    .clk    (clk),
    .adv    (adv),
    .side_i (side2_r),
    .side_o (side_d)
  );

  // hold flags level with the coordinate units
  always_ff @(posedge clk) begin
    if (adv) begin
      fl_r[0].dok  <= side_d.dok;
      fl_r[0].inpl <= side_d.inpl;
      fl_r[0].tp   <= tp_w;
      for (int k = 1; k < CRD_LAT; k++) begin
        fl_r[k] <= fl_r[k-1];
      end
    end
  end

  // faces: in-plane segments use the rectangle boundary crossings, others
  // need t in range and both remaining coordinates inside the face
  always_comb begin
    int third;
    int jj;
    sbi_pkg::flag_t f;
    f       = fl_r[CRD_LAT-1];
    hit_nxt = 1'b0;
    for (int a = 0; a < NAX; a++) begin
      rect_c[a] = 1'b0;
      for (int q = 0; q < NAX; q++) begin
        if (q != a) begin
          third = 3 - a - q;
          jj    = (sbi_pkg::oth(q, 0) == third) ? 0 : 1;
          for (int p = 0; p < 2; p++) begin
            rect_c[a] = rect_c[a] | (f.dok[q] & f.tp[q][p] & inr_w[q][p][jj]);
          end
        end
      end
      for (int p = 0; p < 2; p++) begin
        hit_nxt = hit_nxt | (f.inpl[a][p] ? rect_c[a] :
                  (f.dok[a] & f.tp[a][p] & inr_w[a][p][0] & inr_w[a][p][1]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit_r <= hit_nxt;
    end
  end

  // output register with one skid slot
  assign deliver = adv && v_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_tready) begin
      if (skid_v_r) begin
        out_v_r   <= 1'b1;
        out_hit_r <= skid_hit_r;
        skid_v_r  <= 1'b0;
      end else begin
        out_v_r <= deliver;
        if (deliver) begin
          out_hit_r <= hit_r;
        end
      end
    end else if (deliver) begin
      skid_v_r   <= 1'b1;
      skid_hit_r <= hit_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'b0, out_hit_r};

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_tready && deliver) |=> skid_v_r)
    else $error("stalled result not caught by skid slot");

  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && out_tready) |=> (out_v_r && !skid_v_r))
    else $error("skid slot did not drain into output register");

  a_skid_owner: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid slot full with empty output register");

endmodule

`default_nettype wire
